[rtl/kst_pkg.sv]
// types and constants shared by the spanning tree savings block
package kst_pkg;

    localparam int SUM_W = 26;

    typedef struct packed {
        logic [7:0]  endpoint_a;
        logic [7:0]  endpoint_b;
        logic [15:0] edge_weight;
        logic        last_edge;
    } kst_in_t;

    typedef struct packed {
        logic [SUM_W-1:0] unused_weight;
        logic [SUM_W-1:0] forest_weight;
        logic             input_error;
    } kst_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT_I,
        S_SORT_KEY,
        S_SORT_CMP,
        S_SORT_PUT,
        S_CLR,
        S_KR_I,
        S_KR_EDGE,
        S_FIND_A,
        S_FIND_B,
        S_DONE
    } kst_state_t;

endpackage

[rtl/kruskal_spanning_tree_savings.sv]
// Minimum spanning forest savings. Edges are taken one per cycle while the block is idle; those
// in range are written into the edge memory with a running weight total. After the edge marked
// last the block stalls its input and works over the batch with one compare and add unit: an
// insertion sort by weight in the edge memory, a pass over all MAX_NODES entries that resets
// the parent memory to singletons, then Kruskal over the sorted edges with a root search in
// the parent memory for each endpoint. Sorting is the dominant cost for large batches. The
// result sits in an output register, so the next batch may load while it waits.
module kruskal_spanning_tree_savings
    import kst_pkg::*;
#(
    parameter int MAX_NODES   = 256,
    parameter int MAX_EDGES   = 1024,
    parameter int WEIGHT_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       edge_valid,
    output logic       edge_stall,
    input  kst_in_t    edge_data,
    output logic       result_valid,
    input  logic       result_stall,
    output kst_out_t   result_data,
    input  logic       node_count_we,
    input  logic [8:0] node_count_wdata
);

    localparam int NODE_BITS = $clog2(MAX_NODES);
    localparam int EC_W      = $clog2(MAX_EDGES + 1);
    localparam int EA_W      = MAX_EDGES > 1 ? $clog2(MAX_EDGES) : 1;
    localparam int EW        = WEIGHT_BITS + 2 * NODE_BITS;
    localparam int CMP_W     = 17;
    localparam logic [CMP_W-1:0] MAXN_V = CMP_W'(MAX_NODES);
    localparam logic [EC_W-1:0]  MAXE_V = EC_W'(MAX_EDGES);
    localparam logic [NODE_BITS-1:0] LAST_NODE = NODE_BITS'(MAX_NODES - 1);

    kst_state_t state_reg, state_next;

    logic [8:0]           node_count_reg;
    logic [EC_W-1:0]      edge_count_reg, edge_count_next;
    logic [SUM_W-1:0]     total_reg, total_next;
    logic [SUM_W-1:0]     forest_reg, forest_next;
    logic                 error_reg, error_next;
    logic [EC_W-1:0]      i_reg, i_next;
    logic [EC_W-1:0]      j_reg, j_next;
    logic [NODE_BITS-1:0] k_reg, k_next;
    logic [NODE_BITS-1:0] x_reg, x_next;
    logic [NODE_BITS-1:0] ra_reg, ra_next;
    logic [EW-1:0]        key_reg, key_next;
    logic [EW-1:0]        cur_reg, cur_next;
    logic                 res_valid_reg, res_valid_next;
    kst_out_t             res_reg, res_next;

    // edge memory ports
    logic                 e_we;
    logic [EA_W-1:0]      e_wr_addr, e_rd_addr;
    logic [EW-1:0]        e_wr_data, e_rd_data;
    // parent memory ports
    logic                 p_we;
    logic [NODE_BITS-1:0] p_wr_addr, p_rd_addr, p_wr_data, p_rd_data;

    logic                   accept;
    logic [CMP_W-1:0]       a_ext, b_ext, nc_ext;
    logic                   edge_ok;
    logic [WEIGHT_BITS-1:0] in_w;
    logic [EW-1:0]          in_rec;
    logic                   out_free;
    logic [WEIGHT_BITS-1:0] rd_w, key_w, cur_w;

    kst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk     (clk),
        .we      (e_we),
        .wr_addr (e_wr_addr),
        .wr_data (e_wr_data),
        .rd_addr (e_rd_addr),
        .rd_data (e_rd_data)
    );

    kst_ram #(.WIDTH(NODE_BITS), .DEPTH(MAX_NODES)) u_parent_ram (
        .clk     (clk),
        .we      (p_we),
        .wr_addr (p_wr_addr),
        .wr_data (p_wr_data),
        .rd_addr (p_rd_addr),
        .rd_data (p_rd_data)
    );

    assign edge_stall   = (state_reg != S_IDLE);
    assign accept       = edge_valid && !edge_stall;
    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;
    assign out_free     = !res_valid_reg || !result_stall;

    assign a_ext   = CMP_W'(edge_data.endpoint_a);
    assign b_ext   = CMP_W'(edge_data.endpoint_b);
    assign nc_ext  = CMP_W'(node_count_reg);
    assign edge_ok = (a_ext < nc_ext) && (a_ext < MAXN_V) && (b_ext < nc_ext)
                     && (b_ext < MAXN_V) && (edge_count_reg != MAXE_V);
    assign in_w    = WEIGHT_BITS'(edge_data.edge_weight);
    assign in_rec  = {in_w, NODE_BITS'(edge_data.endpoint_a), NODE_BITS'(edge_data.endpoint_b)};

    // record layout: weight, endpoint a, endpoint b
    assign rd_w  = e_rd_data[EW-1 -: WEIGHT_BITS];
    assign key_w = key_reg[EW-1 -: WEIGHT_BITS];
    assign cur_w = cur_reg[EW-1 -: WEIGHT_BITS];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && edge_data.last_edge)
                begin
                    state_next = S_SORT_I;
                end
            end
            S_SORT_I:
            begin
                state_next = (i_reg >= edge_count_reg) ? S_CLR : S_SORT_KEY;
            end
            S_SORT_KEY:
            begin
                state_next = S_SORT_CMP;
            end
            S_SORT_CMP:
            begin
                if (rd_w > key_w)
                begin
                    state_next = (j_reg == EC_W'(1)) ? S_SORT_PUT : S_SORT_CMP;
                end
                else
                begin
                    state_next = S_SORT_I;
                end
            end
            S_SORT_PUT:
            begin
                state_next = S_SORT_I;
            end
            S_CLR:
            begin
                if (k_reg == LAST_NODE)
                begin
                    state_next = S_KR_I;
                end
            end
            S_KR_I:
            begin
                state_next = (i_reg == edge_count_reg) ? S_DONE : S_KR_EDGE;
            end
            S_KR_EDGE:
            begin
                state_next = S_FIND_A;
            end
            S_FIND_A:
            begin
                if (p_rd_data == x_reg)
                begin
                    state_next = S_FIND_B;
                end
            end
            S_FIND_B:
            begin
                if (p_rd_data == x_reg)
                begin
                    state_next = S_KR_I;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        edge_count_next = edge_count_reg;
        total_next      = total_reg;
        forest_next     = forest_reg;
        error_next      = error_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        x_next          = x_reg;
        ra_next         = ra_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        res_next        = res_reg;
        res_valid_next  = res_valid_reg && result_stall;
        e_we            = 1'b0;
        e_wr_addr       = EA_W'(edge_count_reg);
        e_wr_data       = in_rec;
        e_rd_addr       = EA_W'(i_reg);
        p_we            = 1'b0;
        p_wr_addr       = k_reg;
        p_wr_data       = k_reg;
        p_rd_addr       = x_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (edge_ok)
                    begin
                        e_we            = 1'b1;
                        edge_count_next = edge_count_reg + EC_W'(1);
                        total_next      = total_reg + SUM_W'(in_w);
                    end
                    else
                    begin
                        error_next = 1'b1;
                    end
                    i_next = EC_W'(1);
                end
            end
            S_SORT_I:
            begin
                e_rd_addr = EA_W'(i_reg);
            end
            S_SORT_KEY:
            begin
                key_next  = e_rd_data;
                j_next    = i_reg;
                e_rd_addr = EA_W'(i_reg - EC_W'(1));
            end
            S_SORT_CMP:
            begin
                // entry j-1 is on the read port; shift it up while heavier than the key
                e_we      = 1'b1;
                e_wr_addr = EA_W'(j_reg);
                e_rd_addr = EA_W'(j_reg - EC_W'(2));
                if (rd_w > key_w)
                begin
                    e_wr_data = e_rd_data;
                    j_next    = j_reg - EC_W'(1);
                end
                else
                begin
                    e_wr_data = key_reg;
                    i_next    = i_reg + EC_W'(1);
                end
            end
            S_SORT_PUT:
            begin
                e_we      = 1'b1;
                e_wr_addr = '0;
                e_wr_data = key_reg;
                i_next    = i_reg + EC_W'(1);
            end
            S_CLR:
            begin
                p_we   = 1'b1;
                k_next = k_reg + NODE_BITS'(1);
                i_next = '0;
                forest_next = '0;
            end
            S_KR_I:
            begin
                e_rd_addr = EA_W'(i_reg);
            end
            S_KR_EDGE:
            begin
                cur_next  = e_rd_data;
                x_next    = e_rd_data[NODE_BITS +: NODE_BITS];
                p_rd_addr = e_rd_data[NODE_BITS +: NODE_BITS];
            end
            S_FIND_A:
            begin
                if (p_rd_data == x_reg)
                begin
                    ra_next   = x_reg;
                    x_next    = cur_reg[NODE_BITS-1:0];
                    p_rd_addr = cur_reg[NODE_BITS-1:0];
                end
                else
                begin
                    x_next    = p_rd_data;
                    p_rd_addr = p_rd_data;
                end
            end
            S_FIND_B:
            begin
                if (p_rd_data == x_reg)
                begin
                    i_next = i_reg + EC_W'(1);
                    // link the two roots when the edge joins separate trees
                    if (ra_reg != x_reg)
                    begin
                        p_we        = 1'b1;
                        p_wr_addr   = ra_reg;
                        p_wr_data   = x_reg;
                        forest_next = forest_reg + SUM_W'(cur_w);
                    end
                end
                else
                begin
                    x_next    = p_rd_data;
                    p_rd_addr = p_rd_data;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.unused_weight = total_reg - forest_reg;
                    res_next.forest_weight = forest_reg;
                    res_next.input_error   = error_reg;
                    edge_count_next        = '0;
                    total_next             = '0;
                    error_next             = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= 9'd256;
            edge_count_reg <= '0;
            total_reg      <= '0;
            error_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            total_reg      <= total_next;
            error_reg      <= error_next;
            res_valid_reg  <= res_valid_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            if (node_count_we)
            begin
                node_count_reg <= node_count_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        forest_reg <= forest_next;
        x_reg      <= x_next;
        ra_reg     <= ra_next;
        key_reg    <= key_next;
        cur_reg    <= cur_next;
        res_reg    <= res_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        edge_count_reg <= MAXE_V)
        else $error("edge count beyond capacity");

    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && edge_data.last_edge) |=> (state_reg == S_SORT_I))
        else $error("last edge did not start the sort");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=>
            (edge_count_reg == '0 && total_reg == '0 && res_valid_reg))
        else $error("batch not cleared when result issued");

endmodule

[rtl/kst_ram.sv]
// generic simple dual port ram, one write port and one registered read port
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
